### design/u2c_pkg.sv
package u2c_pkg;

    // Number of registered stages from the input register to the result register.
    localparam int NUM_STAGES = 7;

    // One load enable per stage; bit 0 is the input register.
    typedef logic [NUM_STAGES-1:0] t_ld;

    // Day split: seconds / 86400 is done as (seconds >> 7) / 675.
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [25:0] DAY_RECIP    = 26'd50903316;   // floor(2^35 / 675)
    localparam int          DAY_SHIFT    = 35;

    // Hour split: seconds of day / 3600.
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [10:0] HOUR_RECIP    = 11'd1165;       // floor(2^22 / 3600)
    localparam int          HOUR_SHIFT    = 22;

    // Minute split: seconds of hour / 60.
    localparam logic [5:0]  SECS_PER_MIN = 6'd60;
    localparam logic [10:0] MIN_RECIP    = 11'd1092;        // floor(2^16 / 60)
    localparam int          MIN_SHIFT    = 16;

    // Four-year cycles counted from 1968-01-01, which is 731 days before the epoch.
    localparam logic [15:0] EPOCH_TO_1968 = 16'd731;
    localparam logic [10:0] CYCLE_DAYS    = 11'd1461;
    localparam logic [15:0] CYCLE_RECIP   = 16'd45933;      // floor(2^26 / 1461)
    localparam int          CYCLE_SHIFT   = 26;
    localparam logic [11:0] BASE_YEAR     = 12'd1968;

    // 2100 is not a leap year; from 2100-03-01 on, a day is inserted so that the
    // plain every-fourth-year rule lands on the right date.
    localparam logic [15:0] DAY_2100_MAR1 = 16'd47541;

    // Weekday: (days + 4) mod 7, since the epoch day is a Thursday.
    localparam logic [2:0]  EPOCH_WDAY  = 3'd4;
    localparam logic [2:0]  DAYS_A_WEEK = 3'd7;
    localparam logic [16:0] WEEK_RECIP  = 17'd74898;        // floor(2^19 / 7)
    localparam int          WEEK_SHIFT  = 19;

    // Day of year (from 0) on which a month starts.
    function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
        logic [8:0] base;
        case (m)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (m >= 4'd3)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

### design/unix_seconds_to_calendar.sv
// Channel   Direction  Handshake          Payload
// input     in         i_valid, o_stall   i_epoch_seconds (32 bits)
// result    out        o_valid, i_stall   o_year, o_month, o_day_of_month, o_weekday,
//                                         o_hour, o_minute, o_second
//
// A word is taken every cycle while o_stall is low; its result passes through the
// seven registers in its path (input, day product, day correction, hour/cycle/week
// products, their corrections, minute product with the year split, result
// register).
// Reset clears only the stage valid bits; nothing is kept between words.
// A stalled result holds in the result register while earlier stages keep filling
// any empty slots; o_stall rises only when every stage holds a word.
module unix_seconds_to_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [2:0]  o_weekday,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);
    import u2c_pkg::*;

    logic [NUM_STAGES-1:0] r_v;
    logic [31:0]           r_ts;
    t_ld                   n_ld;
    logic [15:0]           days;
    logic [16:0]           secs;

    // A stage loads when it is empty or the stage after it moves on.
    always_comb begin
        n_ld[NUM_STAGES-1] = !r_v[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            n_ld[k] = !r_v[k] || n_ld[k+1];
        end
    end

    assign o_stall = !n_ld[0];
    assign o_valid = r_v[NUM_STAGES-1];

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (n_ld[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (n_ld[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (n_ld[0]) begin
            r_ts <= i_epoch_seconds;
        end
    end

    u2c_split u_split (
        .i_clk  (i_clk),
        .i_ld   (n_ld),
        .i_ts   (r_ts),
        .o_days (days),
        .o_secs (secs)
    );

    u2c_clock u_clock (
        .i_clk    (i_clk),
        .i_ld     (n_ld),
        .i_secs   (secs),
        .o_hour   (o_hour),
        .o_minute (o_minute),
        .o_second (o_second)
    );

    u2c_date u_date (
        .i_clk   (i_clk),
        .i_ld    (n_ld),
        .i_days  (days),
        .o_year  (o_year),
        .o_month (o_month),
        .o_day   (o_day_of_month),
        .o_wday  (o_weekday)
    );

    // The input is held off only when every stage is occupied.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v == '1))
        else $error("input stalled while a stage is empty");

    // An accepted word always lands in the input stage.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v[0])
        else $error("accepted word not captured");

    // Date fields stay in their calendar ranges.
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month >= 4'd1 && o_month <= 4'd12 && o_day_of_month != 5'd0
                     && o_weekday <= 3'd6 && o_year >= 12'd1970 && o_year <= 12'd2106))
        else $error("date field out of range");

    // Time fields stay in their ranges.
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hour <= 5'd23 && o_minute <= 6'd59 && o_second <= 6'd59))
        else $error("time field out of range");

endmodule

### design/u2c_split.sv
module u2c_split (
    input  logic               i_clk,
    input  u2c_pkg::t_ld       i_ld,
    input  logic [31:0]        i_ts,
    output logic [15:0]        o_days,
    output logic [16:0]        o_secs
);
    import u2c_pkg::*;

    logic [31:0] r_ts;
    logic [50:0] r_prod;
    logic [15:0] r_days;
    logic [16:0] r_secs;

    logic [15:0] n_est;
    logic [32:0] n_full;
    logic [17:0] n_rem;
    logic [15:0] n_days;
    logic [16:0] n_secs;

    // Stage 1: reciprocal product for the day count.
    always_ff @(posedge i_clk) begin
        if (i_ld[1]) begin
            r_ts   <= i_ts;
            r_prod <= 51'(i_ts[31:7]) * 51'(DAY_RECIP);
        end
    end

    // The estimate is at most one low; one compare and subtract fixes it.
    always_comb begin
        n_est  = r_prod[DAY_SHIFT +: 16];
        n_full = 33'(r_ts) - (33'(n_est) * 33'(SECS_PER_DAY));
        n_rem  = n_full[17:0];
        if (n_rem >= 18'(SECS_PER_DAY)) begin
            n_days = n_est + 16'd1;
            n_secs = 17'(n_rem - 18'(SECS_PER_DAY));
        end else begin
            n_days = n_est;
            n_secs = n_rem[16:0];
        end
    end

    // Stage 2: day count and second of day.
    always_ff @(posedge i_clk) begin
        if (i_ld[2]) begin
            r_days <= n_days;
            r_secs <= n_secs;
        end
    end

    assign o_days = r_days;
    assign o_secs = r_secs;

endmodule

### design/u2c_clock.sv
module u2c_clock (
    input  logic               i_clk,
    input  u2c_pkg::t_ld       i_ld,
    input  logic [16:0]        i_secs,
    output logic [4:0]         o_hour,
    output logic [5:0]         o_minute,
    output logic [5:0]         o_second
);
    import u2c_pkg::*;

    logic [16:0] r_secs3;
    logic [27:0] r_ph;
    logic [4:0]  r_hour4;
    logic [11:0] r_hrem4;
    logic [4:0]  r_hour5;
    logic [11:0] r_hrem5;
    logic [22:0] r_pm;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute;
    logic [5:0]  r_second;

    logic [4:0]  n_hest;
    logic [16:0] n_hfull;
    logic [12:0] n_hrem13;
    logic [4:0]  n_hour;
    logic [11:0] n_hrem;
    logic [5:0]  n_mest;
    logic [11:0] n_sfull;
    logic [6:0]  n_srem;
    logic [5:0]  n_minute;
    logic [5:0]  n_second;

    // Stage 3: reciprocal product for the hour.
    always_ff @(posedge i_clk) begin
        if (i_ld[3]) begin
            r_secs3 <= i_secs;
            r_ph    <= 28'(i_secs) * 28'(HOUR_RECIP);
        end
    end

    // Hour correction and seconds left within the hour.
    always_comb begin
        n_hest   = r_ph[HOUR_SHIFT +: 5];
        n_hfull  = r_secs3 - (17'(n_hest) * 17'(SECS_PER_HOUR));
        n_hrem13 = n_hfull[12:0];
        if (n_hrem13 >= 13'(SECS_PER_HOUR)) begin
            n_hour = n_hest + 5'd1;
            n_hrem = 12'(n_hrem13 - 13'(SECS_PER_HOUR));
        end else begin
            n_hour = n_hest;
            n_hrem = n_hrem13[11:0];
        end
    end

    // Stage 4: hour and remainder.
    always_ff @(posedge i_clk) begin
        if (i_ld[4]) begin
            r_hour4 <= n_hour;
            r_hrem4 <= n_hrem;
        end
    end

    // Stage 5: reciprocal product for the minute.
    always_ff @(posedge i_clk) begin
        if (i_ld[5]) begin
            r_hour5 <= r_hour4;
            r_hrem5 <= r_hrem4;
            r_pm    <= 23'(r_hrem4) * 23'(MIN_RECIP);
        end
    end

    // Minute correction; what is left is the second.
    always_comb begin
        n_mest  = r_pm[MIN_SHIFT +: 6];
        n_sfull = r_hrem5 - (12'(n_mest) * 12'(SECS_PER_MIN));
        n_srem  = n_sfull[6:0];
        if (n_srem >= 7'(SECS_PER_MIN)) begin
            n_minute = n_mest + 6'd1;
            n_second = 6'(n_srem - 7'(SECS_PER_MIN));
        end else begin
            n_minute = n_mest;
            n_second = n_srem[5:0];
        end
    end

    // Stage 6: result register.
    always_ff @(posedge i_clk) begin
        if (i_ld[6]) begin
            r_hour   <= r_hour5;
            r_minute <= n_minute;
            r_second <= n_second;
        end
    end

    assign o_hour   = r_hour;
    assign o_minute = r_minute;
    assign o_second = r_second;

endmodule

### design/u2c_date.sv
module u2c_date (
    input  logic               i_clk,
    input  u2c_pkg::t_ld       i_ld,
    input  logic [15:0]        i_days,
    output logic [11:0]        o_year,
    output logic [3:0]         o_month,
    output logic [4:0]         o_day,
    output logic [2:0]         o_wday
);
    import u2c_pkg::*;

    logic [15:0] r_dp;
    logic [31:0] r_pd;
    logic [15:0] r_wx;
    logic [32:0] r_pw;
    logic [5:0]  r_cyc;
    logic [10:0] r_cr;
    logic [2:0]  r_wday4;
    logic [11:0] r_year5;
    logic [8:0]  r_yday;
    logic        r_leap;
    logic [2:0]  r_wday5;
    logic [11:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    logic [2:0]  r_wday;

    logic [15:0] n_dp;
    logic [15:0] n_wx;
    logic [5:0]  n_cest;
    logic [15:0] n_cfull;
    logic [11:0] n_cr12;
    logic [5:0]  n_cyc;
    logic [10:0] n_cr;
    logic [13:0] n_west;
    logic [15:0] n_wfull;
    logic [3:0]  n_wr;
    logic [2:0]  n_wday;
    logic [1:0]  n_yi;
    logic [10:0] n_ystart;
    logic [10:0] n_yday;
    logic [10:0] n_ge;
    logic [3:0]  n_month;
    logic [8:0]  n_dfull;

    // Days from 1968-01-01, with the missing leap day of 2100 put back in.
    always_comb begin
        n_dp = i_days + EPOCH_TO_1968 + 16'(i_days >= DAY_2100_MAR1);
        n_wx = i_days + 16'(EPOCH_WDAY);
    end

    // Stage 3: reciprocal products for the four-year cycle and the week.
    always_ff @(posedge i_clk) begin
        if (i_ld[3]) begin
            r_dp <= n_dp;
            r_pd <= 32'(n_dp) * 32'(CYCLE_RECIP);
            r_wx <= n_wx;
            r_pw <= 33'(n_wx) * 33'(WEEK_RECIP);
        end
    end

    // Cycle index, day within the cycle, and weekday, each corrected once.
    always_comb begin
        n_cest  = r_pd[CYCLE_SHIFT +: 6];
        n_cfull = r_dp - (16'(n_cest) * 16'(CYCLE_DAYS));
        n_cr12  = n_cfull[11:0];
        if (n_cr12 >= 12'(CYCLE_DAYS)) begin
            n_cyc = n_cest + 6'd1;
            n_cr  = 11'(n_cr12 - 12'(CYCLE_DAYS));
        end else begin
            n_cyc = n_cest;
            n_cr  = n_cr12[10:0];
        end

        n_west  = r_pw[WEEK_SHIFT +: 14];
        n_wfull = r_wx - (16'(n_west) * 16'(DAYS_A_WEEK));
        n_wr    = n_wfull[3:0];
        if (n_wr >= 4'(DAYS_A_WEEK)) begin
            n_wday = 3'(n_wr - 4'(DAYS_A_WEEK));
        end else begin
            n_wday = n_wr[2:0];
        end
    end

    // Stage 4: cycle position and weekday.
    always_ff @(posedge i_clk) begin
        if (i_ld[4]) begin
            r_cyc   <= n_cyc;
            r_cr    <= n_cr;
            r_wday4 <= n_wday;
        end
    end

    // Year within the cycle: the first year of each cycle is the leap year.
    always_comb begin
        if (r_cr < 11'd366) begin
            n_yi     = 2'd0;
            n_ystart = 11'd0;
        end else if (r_cr < 11'd731) begin
            n_yi     = 2'd1;
            n_ystart = 11'd366;
        end else if (r_cr < 11'd1096) begin
            n_yi     = 2'd2;
            n_ystart = 11'd731;
        end else begin
            n_yi     = 2'd3;
            n_ystart = 11'd1096;
        end
        n_yday = r_cr - n_ystart;
    end

    // Stage 5: year, day of year and leap flag.
    always_ff @(posedge i_clk) begin
        if (i_ld[5]) begin
            r_year5 <= BASE_YEAR + {4'd0, r_cyc, 2'b00} + 12'(n_yi);
            r_yday  <= n_yday[8:0];
            r_leap  <= (n_yi == 2'd0);
            r_wday5 <= r_wday4;
        end
    end

    // Month is one plus the number of later month starts already reached.
    always_comb begin
        for (int m = 0; m < 11; m++) begin
            n_ge[m] = (r_yday >= month_start(4'(m + 2), r_leap));
        end
        n_month = 4'd1 + 4'($countones(n_ge));
        n_dfull = r_yday - month_start(n_month, r_leap) + 9'd1;
    end

    // Stage 6: result register.
    always_ff @(posedge i_clk) begin
        if (i_ld[6]) begin
            r_year  <= r_year5;
            r_month <= n_month;
            r_day   <= n_dfull[4:0];
            r_wday  <= r_wday5;
        end
    end

    assign o_year  = r_year;
    assign o_month = r_month;
    assign o_day   = r_day;
    assign o_wday  = r_wday;

endmodule

### test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import u2c_pkg::*;

    // One decoded calendar instant, laid out like the result ports.
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [2:0]  wday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_cal;

    // A pending result together with the timestamp that produced it.
    typedef struct packed {
        logic [31:0] stamp;
        t_cal        cal;
    } t_pending;

    // One directed row; the calendar is only meaningful when hand_typed is set.
    typedef struct packed {
        logic [31:0] stamp;
        logic        hand_typed;
        t_cal        cal;
    } t_stim_row;

    localparam int NUM_RANDOM   = 400;
    localparam int QUIET_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 10;
    localparam int unsigned SECS_DAY  = 86400;
    localparam int unsigned SECS_HOUR = 3600;
    localparam int unsigned SECS_MIN  = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_epoch_seconds;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [11:0] o_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day_of_month;
    logic [2:0]  o_weekday;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [5:0]  o_second;

    t_pending    calendar_q[$];
    int unsigned mismatches = 0;
    int unsigned words_sent = 0;
    int unsigned results_checked = 0;
    int unsigned quiet_cycles = 0;
    int unsigned stall_left = 0;
    bit          src_idle_on = 1'b1;
    bit          sink_stall_on = 1'b1;

    unix_seconds_to_calendar u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_epoch_seconds (i_epoch_seconds),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day_of_month  (o_day_of_month),
        .o_weekday       (o_weekday),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Gregorian leap rule: every fourth year, but centuries only when divisible by 400.
    function automatic bit is_leap(input int unsigned yr);
        return ((yr % 4) == 0 && (yr % 100) != 0) || ((yr % 400) == 0);
    endfunction

    function automatic int unsigned month_length(input int unsigned yr, input int unsigned mon);
        int unsigned lens[12];
        lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (mon == 2 && is_leap(yr)) begin
            return 29;
        end
        return lens[mon - 1];
    endfunction

    // Expected calendar for a timestamp: split off the time of day, then walk
    // the day count forward year by year and month by month from 1970.
    function automatic t_cal calendar_of(input logic [31:0] stamp);
        int unsigned days;
        int unsigned tod;
        int unsigned left;
        int unsigned yr;
        int unsigned mon;
        t_cal        c;
        days = stamp / SECS_DAY;
        tod  = stamp % SECS_DAY;
        left = days;
        yr   = 1970;
        mon  = 1;
        while (left >= (is_leap(yr) ? 366 : 365)) begin
            left = left - (is_leap(yr) ? 366 : 365);
            yr++;
        end
        while (mon < 12 && left >= month_length(yr, mon)) begin
            left = left - month_length(yr, mon);
            mon++;
        end
        c.year   = 12'(yr);
        c.month  = 4'(mon);
        c.mday   = 5'(left + 1);
        c.wday   = 3'((days + 4) % 7);
        c.hour   = 5'(tod / SECS_HOUR);
        c.minute = 6'((tod % SECS_HOUR) / SECS_MIN);
        c.second = 6'(tod % SECS_MIN);
        return c;
    endfunction

    // Idle run length: mostly none, sometimes a short one, rarely a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Offer one word and hold it until accepted, then possibly idle.
    task automatic send_word(input logic [31:0] stamp, input t_cal cal);
        int unsigned gap;
        calendar_q.push_back('{stamp: stamp, cal: cal});
        i_valid         <= 1'b1;
        i_epoch_seconds <= stamp;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        words_sent++;
        gap = src_idle_on ? idle_len() : 0;
        if (gap != 0) begin
            i_valid         <= 1'b0;
            i_epoch_seconds <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Result side back-pressure, independent of o_valid.
    always @(posedge i_clk) begin
        if (!i_rst_n || !sink_stall_on) begin
            i_stall <= 1'b0;
        end else if (stall_left != 0) begin
            i_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_stall <= 1'b0;
            stall_left = idle_len();
        end
    end

    // Count cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("Timeout: no word moved for %0d cycles, %0d results still pending.",
                 QUIET_LIMIT, calendar_q.size());
        $display("testbench: FAIL");
        $finish;
    end

    task automatic note_mismatch(input string field, input logic [31:0] stamp,
                                 input logic [31:0] want, input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("Mismatch on %s for seconds %0d: expected %0d, got %0d",
                     field, stamp, want, got);
        end
    endtask

    // Compare each accepted result with the oldest pending calendar.
    always @(posedge i_clk) begin
        t_pending p;
        if (i_rst_n && o_valid && !i_stall) begin
            if (calendar_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("Unexpected result word: %0d-%0d-%0d %0d:%0d:%0d",
                             o_year, o_month, o_day_of_month, o_hour, o_minute, o_second);
                end
            end else begin
                p = calendar_q.pop_front();
                results_checked++;
                if (o_year !== p.cal.year)
                    note_mismatch("year", p.stamp, 32'(p.cal.year), 32'(o_year));
                if (o_month !== p.cal.month)
                    note_mismatch("month", p.stamp, 32'(p.cal.month), 32'(o_month));
                if (o_day_of_month !== p.cal.mday)
                    note_mismatch("day_of_month", p.stamp, 32'(p.cal.mday),
                                  32'(o_day_of_month));
                if (o_weekday !== p.cal.wday)
                    note_mismatch("weekday", p.stamp, 32'(p.cal.wday), 32'(o_weekday));
                if (o_hour !== p.cal.hour)
                    note_mismatch("hour", p.stamp, 32'(p.cal.hour), 32'(o_hour));
                if (o_minute !== p.cal.minute)
                    note_mismatch("minute", p.stamp, 32'(p.cal.minute), 32'(o_minute));
                if (o_second !== p.cal.second)
                    note_mismatch("second", p.stamp, 32'(p.cal.second), 32'(o_second));
            end
        end
    end

    // Directed timestamps: epoch, day/year/month edges, leap days, the 2100
    // non-leap century, the signed 32-bit rollover, bit patterns and the maximum.
    t_stim_row directed[] = '{
        '{32'd0,          1'b1, '{12'd1970, 4'd1, 5'd1, 3'd4, 5'd0,  6'd0,  6'd0}},
        '{32'd59,         1'b0, '0},
        '{32'd60,         1'b0, '0},
        '{32'd3599,       1'b0, '0},
        '{32'd3600,       1'b0, '0},
        '{32'd86399,      1'b1, '{12'd1970, 4'd1, 5'd1, 3'd4, 5'd23, 6'd59, 6'd59}},
        '{32'd86400,      1'b1, '{12'd1970, 4'd1, 5'd2, 3'd5, 5'd0,  6'd0,  6'd0}},
        '{32'd31535999,   1'b0, '0},
        '{32'd31536000,   1'b0, '0},
        '{32'd68169599,   1'b0, '0},
        '{32'd68169600,   1'b0, '0},
        '{32'd68255999,   1'b0, '0},
        '{32'd946684799,  1'b0, '0},
        '{32'd951782400,  1'b0, '0},
        '{32'd951868800,  1'b0, '0},
        '{32'd2147483647, 1'b0, '0},
        '{32'd2147483648, 1'b0, '0},
        '{32'd4102444799, 1'b0, '0},
        '{32'd4107542399, 1'b0, '0},
        '{32'd4107542400, 1'b0, '0},
        '{32'hAAAAAAAA,   1'b0, '0},
        '{32'h55555555,   1'b0, '0},
        '{32'd4294944000, 1'b0, '0},
        '{32'hFFFFFFFF,   1'b1, '{12'd2106, 4'd2, 5'd7, 3'd0, 5'd6,  6'd28, 6'd15}}
    };

    // Main sequence: reset, directed rows, then random timestamps in four
    // flow-control phases.
    initial begin
        int unsigned  yr;
        int unsigned  mon;
        int unsigned  day_no;
        int unsigned  phase;
        longint unsigned stamp64;
        logic [31:0]  stamp;

        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_epoch_seconds = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            send_word(directed[k].stamp, directed[k].hand_typed ? directed[k].cal
                                                                : calendar_of(directed[k].stamp));
        end

        for (int n = 0; n < NUM_RANDOM; n++) begin
            // Phases: full rate, both sides idling, sink stalls only, source gaps only.
            if (n % 100 == 0) begin
                phase         = n / 100;
                src_idle_on   = (phase == 1) || (phase == 3);
                sink_stall_on = (phase == 1) || (phase == 2);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    stamp = $urandom;
                end
                4, 5, 6, 7: begin
                    // First or last day of a random month, near midnight.
                    yr     = $urandom_range(1970, 2106);
                    mon    = $urandom_range(1, 12);
                    day_no = 0;
                    for (int y = 1970; y < yr; y++) begin
                        day_no += is_leap(y) ? 366 : 365;
                    end
                    for (int m = 1; m < mon; m++) begin
                        day_no += month_length(yr, m);
                    end
                    if ($urandom_range(0, 1) != 0) begin
                        day_no += month_length(yr, mon) - 1;
                    end
                    stamp64 = longint'(day_no) * SECS_DAY;
                    stamp64 += ($urandom_range(0, 1) != 0) ? SECS_DAY - $urandom_range(1, 3)
                                                           : $urandom_range(0, 2);
                    if (stamp64 > 64'hFFFFFFFF) begin
                        stamp64 = 64'hFFFFFFFF - $urandom_range(0, 3 * SECS_DAY);
                    end
                    stamp = stamp64[31:0];
                end
                default: begin
                    stamp = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 200000)
                                                        : 32'hFFFFFFFF - $urandom_range(0, 200000);
                end
            endcase
            send_word(stamp, calendar_of(stamp));
        end

        i_valid <= 1'b0;
        while (calendar_q.size() != 0) @(posedge i_clk);
        repeat (NUM_STAGES + 4) @(posedge i_clk);

        $display("Converted %0d timestamps (%0d directed, %0d random); %0d results checked.",
                 words_sent, directed.size(), NUM_RANDOM, results_checked);
        $display("Flow control ran at full rate, with source gaps, with sink stalls and both; %0d mismatches.",
                 mismatches);
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
design/u2c_pkg.sv
design/u2c_split.sv
design/u2c_clock.sv
design/u2c_date.sv
design/unix_seconds_to_calendar.sv
test/testbench.sv
